// ===== hw/rtl/abld_pkg.sv =====
`timescale 1ns / 1ps
package abld_pkg;

   localparam int SLOTS    = 128;
   localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW       = $clog2(SLOTS + 1);
   localparam int DATA_W   = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   typedef logic [AW-1:0]       slot_type;
   typedef logic [CW-1:0]       cnt_type;
   typedef logic [DATA_W-1:0]   data_type;
   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_PUSH_BACK  = 2'd0;
   localparam action_type ACT_PUSH_FRONT = 2'd1;
   localparam action_type ACT_POP_FRONT  = 2'd2;
   localparam action_type ACT_POP_BACK   = 2'd3;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   localparam cnt_type SLOTS_CNT = CW'(SLOTS);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic     we;
      slot_type waddr;
      logic     re;
      slot_type raddr;
   } ram_ctl_type;

endpackage

// ===== hw/rtl/abld_ram.sv =====
`timescale 1ns / 1ps
module abld_ram #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  abld_pkg::ram_ctl_type ctl,
   input  logic [WIDTH-1:0]     wdata,
   output logic [WIDTH-1:0]     rdata
);
   import abld_pkg::*;

   logic [WIDTH-1:0] store_ff [SLOTS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         store_ff[ctl.waddr] <= wdata;
      end
      if (ctl.re) begin
         rdata_ff <= store_ff[ctl.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/abld_ctrl.sv =====
`timescale 1ns / 1ps
module abld_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  abld_pkg::action_type    req_action,
   input  abld_pkg::data_type      req_push_value,
   output logic                    rsp_valid,
   output abld_pkg::data_type      rsp_pop_value,
   output abld_pkg::status_type    rsp_status,
   output logic [abld_pkg::COUNT_W-1:0] rsp_count,
   output abld_pkg::ram_ctl_type   val_ctl,
   output abld_pkg::data_type      val_wdata,
   input  abld_pkg::data_type      val_rdata,
   output abld_pkg::ram_ctl_type   prev_ctl,
   output abld_pkg::slot_type      prev_wdata,
   input  abld_pkg::slot_type      prev_rdata,
   output abld_pkg::ram_ctl_type   next_ctl,
   output abld_pkg::slot_type      next_wdata,
   input  abld_pkg::slot_type      next_rdata
);
   import abld_pkg::*;

   state_type  state_ff, state_in;
   slot_type   front_ff, front_in;
   slot_type   back_ff, back_in;
   slot_type   free_head_ff, free_head_in;
   cnt_type    count_ff, count_in;
   cnt_type    fresh_ff, fresh_in;
   action_type op_ff, op_in;
   data_type   pv_ff, pv_in;
   slot_type   slot_ff, slot_in;
   logic       from_free_ff, from_free_in;
   logic       ok_ff, ok_in;
   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_pop_value_ff, rsp_pop_value_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic accept;
   assign accept = (state_ff == ST_IDLE) && start;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      logic is_push;
      logic free_avail;
      slot_type new_slot;
      is_push    = ~req_action[1];
      free_avail = (fresh_ff != count_ff);
      new_slot   = free_avail ? free_head_ff : fresh_ff[AW-1:0];

      front_in         = front_ff;
      back_in          = back_ff;
      free_head_in     = free_head_ff;
      count_in         = count_ff;
      fresh_in         = fresh_ff;
      op_in            = op_ff;
      pv_in            = pv_ff;
      slot_in          = slot_ff;
      from_free_in     = from_free_ff;
      ok_in            = ok_ff;
      rsp_valid_in     = 1'b0;
      rsp_pop_value_in = rsp_pop_value_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;

      val_ctl    = '{we: 1'b0, waddr: slot_ff, re: 1'b0, raddr: front_ff};
      prev_ctl   = '{we: 1'b0, waddr: slot_ff, re: 1'b0, raddr: back_ff};
      next_ctl   = '{we: 1'b0, waddr: slot_ff, re: 1'b0, raddr: front_ff};
      val_wdata  = pv_ff;
      prev_wdata = back_ff;
      next_wdata = front_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in        = req_action;
               pv_in        = req_push_value;
               from_free_in = free_avail;
               val_ctl.re   = 1'b1;
               prev_ctl.re  = 1'b1;
               next_ctl.re  = 1'b1;
               val_ctl.raddr  = (req_action == ACT_POP_FRONT) ? front_ff : back_ff;
               next_ctl.raddr = is_push ? free_head_ff : front_ff;
               if (is_push) begin
                  slot_in = new_slot;
                  ok_in   = (count_ff != SLOTS_CNT);
               end else begin
                  slot_in = (req_action == ACT_POP_FRONT) ? front_ff : back_ff;
                  ok_in   = (count_ff != '0);
               end
            end
         end
         ST_EXEC: begin
            rsp_valid_in     = 1'b1;
            rsp_pop_value_in = '0;
            case (op_ff)
               ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                  if (ok_ff) begin
                     rsp_status_in = STATUS_DONE;
                     count_in      = count_ff + CW'(1);
                     if (from_free_ff) begin
                        free_head_in = next_rdata;
                     end else begin
                        fresh_in = fresh_ff + CW'(1);
                     end
                     val_ctl.we    = 1'b1;
                     val_ctl.waddr = slot_ff;
                     val_wdata     = pv_ff;
                     if (count_ff == '0) begin
                        front_in = slot_ff;
                        back_in  = slot_ff;
                     end else if (op_ff == ACT_PUSH_FRONT) begin
                        front_in       = slot_ff;
                        next_ctl.we    = 1'b1;
                        next_ctl.waddr = slot_ff;
                        next_wdata     = front_ff;
                        prev_ctl.we    = 1'b1;
                        prev_ctl.waddr = front_ff;
                        prev_wdata     = slot_ff;
                     end else begin
                        back_in        = slot_ff;
                        prev_ctl.we    = 1'b1;
                        prev_ctl.waddr = slot_ff;
                        prev_wdata     = back_ff;
                        next_ctl.we    = 1'b1;
                        next_ctl.waddr = back_ff;
                        next_wdata     = slot_ff;
                     end
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end
               default: begin
                  if (ok_ff) begin
                     rsp_status_in    = STATUS_DONE;
                     rsp_pop_value_in = val_rdata;
                     count_in         = count_ff - CW'(1);
                     next_ctl.we      = 1'b1;
                     next_ctl.waddr   = slot_ff;
                     next_wdata       = free_head_ff;
                     free_head_in     = slot_ff;
                     if (op_ff == ACT_POP_FRONT) begin
                        front_in = next_rdata;
                     end else begin
                        back_in = prev_rdata;
                     end
                  end else begin
                     rsp_status_in = STATUS_EMPTY;
                  end
               end
            endcase
            rsp_count_in = COUNT_W'(count_in);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         free_head_ff <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      pv_ff            <= pv_in;
      slot_ff          <= slot_in;
      from_free_ff     <= from_free_in;
      ok_ff            <= ok_in;
      rsp_pop_value_ff <= rsp_pop_value_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign busy          = (state_ff == ST_EXEC);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_pop_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;

endmodule

// ===== hw/rtl/array_backed_linked_deque_top.sv =====
`timescale 1ns / 1ps
// Double-ended queue of up to SLOTS signed 32-bit items, held as a doubly
// linked list in on-chip memories (value, prev link, next link). An item is
// taken when start is high and busy is low; busy is then high for one cycle
// while the registered memory reads are applied and links are written back,
// so no new item is taken until busy falls. The result appears in the cycle
// after that, on rsp_* for exactly one cycle with rsp_valid high; it cannot be
// stalled and must be captured then. Freed slots are chained through the
// next-link memory, so no clearing pass runs after reset and the first item
// may be started in the first cycle after reset is released.
module array_backed_linked_deque_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_action,
   input  logic signed [31:0]           req_push_value,
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_pop_value,
   output logic [1:0]                   rsp_status,
   output logic [7:0]                   rsp_count
);
   import abld_pkg::*;

   ram_ctl_type val_ctl, prev_ctl, next_ctl;
   data_type    val_wdata, val_rdata;
   slot_type    prev_wdata, prev_rdata;
   slot_type    next_wdata, next_rdata;
   data_type    pop_value;

   abld_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_push_value (data_type'(req_push_value)),
      .rsp_valid      (rsp_valid),
      .rsp_pop_value  (pop_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .val_ctl        (val_ctl),
      .val_wdata      (val_wdata),
      .val_rdata      (val_rdata),
      .prev_ctl       (prev_ctl),
      .prev_wdata     (prev_wdata),
      .prev_rdata     (prev_rdata),
      .next_ctl       (next_ctl),
      .next_wdata     (next_wdata),
      .next_rdata     (next_rdata)
   );

   assign rsp_pop_value = signed'(pop_value);

   abld_ram #(.WIDTH(DATA_W)) u_val_ram (
      .clock (clock),
      .ctl   (val_ctl),
      .wdata (val_wdata),
      .rdata (val_rdata)
   );

   abld_ram #(.WIDTH(AW)) u_prev_ram (
      .clock (clock),
      .ctl   (prev_ctl),
      .wdata (prev_wdata),
      .rdata (prev_rdata)
   );

   abld_ram #(.WIDTH(AW)) u_next_ram (
      .clock (clock),
      .ctl   (next_ctl),
      .wdata (next_wdata),
      .rdata (next_rdata)
   );

endmodule
